FILE: rtl/mld_pkg.sv
package mld_pkg;

    localparam int SAMPLE_W       = 12;
    localparam int UNIT_W         = 14;
    localparam int ELAPSED_W      = 16;
    localparam int COUNT_W        = 4;
    localparam int KIND_W         = 2;
    localparam int CHAR_W         = 7;
    localparam int PAT_MAX_W      = 16;
    localparam int PATTERN_BITS_DEF = 8;
    localparam int CFG_ADDR_W     = 1;
    localparam int CFG_DATA_W     = 14;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 12'd2500;
    localparam logic [UNIT_W-1:0]   UNIT_RST      = 14'd290;

    localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNIT      = 1'd1;

    localparam logic [KIND_W-1:0] EV_DOT  = 2'd0;
    localparam logic [KIND_W-1:0] EV_DASH = 2'd1;
    localparam logic [KIND_W-1:0] EV_CHAR = 2'd2;
    localparam logic [KIND_W-1:0] EV_WORD = 2'd3;

    localparam logic [CHAR_W-1:0] CH_DOT     = 7'h2E;
    localparam logic [CHAR_W-1:0] CH_DASH    = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_UNKNOWN = 7'h3F;
    localparam logic [CHAR_W-1:0] CH_NONE    = 7'h00;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ON      = 2'd1,
        PH_GAP_SYM = 2'd2,
        PH_GAP_CHR = 2'd3
    } t_phase;

    // Dot bits in pattern (first symbol at bit 0), symbol count in cnt.
    function automatic logic [CHAR_W-1:0] morse_lookup(
        input logic [PAT_MAX_W-1:0] pat,
        input logic [COUNT_W-1:0]   cnt
    );
        logic [CHAR_W-1:0] ch;
        ch = CH_UNKNOWN;
        if (pat[PAT_MAX_W-1:5] == '0) begin
            case ({cnt, pat[4:0]})
                {4'd2, 5'h01}: ch = 7'h41; // A
                {4'd4, 5'h0E}: ch = 7'h42; // B
                {4'd4, 5'h0A}: ch = 7'h43; // C
                {4'd3, 5'h06}: ch = 7'h44; // D
                {4'd1, 5'h01}: ch = 7'h45; // E
                {4'd4, 5'h0B}: ch = 7'h46; // F
                {4'd3, 5'h04}: ch = 7'h47; // G
                {4'd4, 5'h0F}: ch = 7'h48; // H
                {4'd2, 5'h03}: ch = 7'h49; // I
                {4'd4, 5'h01}: ch = 7'h4A; // J
                {4'd3, 5'h02}: ch = 7'h4B; // K
                {4'd4, 5'h0D}: ch = 7'h4C; // L
                {4'd2, 5'h00}: ch = 7'h4D; // M
                {4'd2, 5'h02}: ch = 7'h4E; // N
                {4'd3, 5'h00}: ch = 7'h4F; // O
                {4'd4, 5'h09}: ch = 7'h50; // P
                {4'd4, 5'h04}: ch = 7'h51; // Q
                {4'd3, 5'h05}: ch = 7'h52; // R
                {4'd3, 5'h07}: ch = 7'h53; // S
                {4'd1, 5'h00}: ch = 7'h54; // T
                {4'd3, 5'h03}: ch = 7'h55; // U
                {4'd4, 5'h07}: ch = 7'h56; // V
                {4'd3, 5'h01}: ch = 7'h57; // W
                {4'd4, 5'h06}: ch = 7'h58; // X
                {4'd4, 5'h02}: ch = 7'h59; // Y
                {4'd4, 5'h0C}: ch = 7'h5A; // Z
                {4'd5, 5'h00}: ch = 7'h30;
                {4'd5, 5'h01}: ch = 7'h31;
                {4'd5, 5'h03}: ch = 7'h32;
                {4'd5, 5'h07}: ch = 7'h33;
                {4'd5, 5'h0F}: ch = 7'h34;
                {4'd5, 5'h1F}: ch = 7'h35;
                {4'd5, 5'h1E}: ch = 7'h36;
                {4'd5, 5'h1C}: ch = 7'h37;
                {4'd5, 5'h18}: ch = 7'h38;
                {4'd5, 5'h10}: ch = 7'h39;
                default:       ch = CH_UNKNOWN;
            endcase
        end
        return ch;
    endfunction

endpackage

FILE: rtl/mld_sample_if.sv
interface mld_sample_if
    import mld_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

FILE: rtl/mld_event_if.sv
interface mld_event_if
    import mld_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] event_kind;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, output event_kind, output char_code, input ready);
    modport sink   (input valid, input event_kind, input char_code, output ready);
endinterface

FILE: rtl/morse_light_decoder.sv
// Morse decoder for a sampled light sensor.
// i_sample carries one 12-bit sensor reading per request; o_event carries
// dot, dash, decoded character and word-end events (event_kind, char_code).
// Threshold and unit length are written through i_cfg_we / i_cfg_addr /
// i_cfg_wdata and take effect on the next sample; the user must write
// them only while the block is idle, a rule the block leaves unchecked.
// A sample is taken into an input register; once the output register is
// free or being drained, the phase and timing update runs on it and, when
// an event results, loads the output register.
// One sample per cycle is sustained as long as o_event is drained; the
// input register and the output register each hold one request, so a new
// sample is still taken while an event waits on a stalled receiver.
// When the output register is full and not taken, the input register holds
// its sample and i_sample.ready drops until the event leaves.
// Reset (synchronous, active low) empties both registers, returns the
// decoder to idle with cleared counters, and restores threshold 2500 and
// unit length 290 ticks.
module morse_light_decoder
    import mld_pkg::*;
#(
    parameter int PATTERN_BITS = PATTERN_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    mld_sample_if.sink            i_sample,
    mld_event_if.source           o_event
);

    logic [SAMPLE_W-1:0]     r_threshold;
    logic [UNIT_W-1:0]       r_unit;

    logic                    r_in_vld;
    logic [SAMPLE_W-1:0]     r_in_sample;

    t_phase                  r_phase, n_phase;
    logic [ELAPSED_W-1:0]    r_elapsed, n_elapsed;
    logic [PATTERN_BITS-1:0] r_pattern, n_pattern;
    logic [COUNT_W-1:0]      r_count, n_count;

    logic                    r_out_vld;
    logic [KIND_W-1:0]       r_out_kind;
    logic [CHAR_W-1:0]       r_out_char;

    logic                    in_accept;
    logic                    advance;
    logic                    light_on;
    logic [ELAPSED_W-1:0]    two_u, four_u, el_inc;
    logic [COUNT_W-1:0]      count_inc;
    logic [PATTERN_BITS-1:0] dot_mask;
    logic                    ev_vld;
    logic [KIND_W-1:0]       ev_kind;
    logic [CHAR_W-1:0]       ev_char;

    assign advance   = r_in_vld && (!r_out_vld || o_event.ready);
    assign i_sample.ready = !r_in_vld || advance;
    assign in_accept = i_sample.valid && i_sample.ready;

    assign light_on  = r_in_sample <= r_threshold;
    assign two_u     = {1'b0, r_unit, 1'b0};
    assign four_u    = {r_unit, 2'b00};
    assign el_inc    = (r_elapsed == '1) ? r_elapsed : r_elapsed + 1'b1;
    assign count_inc = (r_count == '1) ? r_count : r_count + 1'b1;

    // One-hot at the current symbol index; empty once the index is past the pattern.
    always_comb begin
        for (int i = 0; i < PATTERN_BITS; i++) begin
            dot_mask[i] = (r_count == COUNT_W'(i));
        end
    end

    // Next state
    always_comb begin
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        n_pattern = r_pattern;
        n_count   = r_count;
        case (r_phase)
            PH_IDLE: begin
                if (light_on) begin
                    n_phase   = PH_ON;
                    n_elapsed = ELAPSED_W'(1);
                end
            end
            PH_ON: begin
                if (light_on) begin
                    n_elapsed = el_inc;
                end else begin
                    if (r_elapsed < two_u) begin
                        n_pattern = r_pattern | dot_mask;
                    end
                    n_count   = count_inc;
                    n_phase   = PH_GAP_SYM;
                    n_elapsed = '0;
                end
            end
            PH_GAP_SYM: begin
                if (light_on) begin
                    n_phase   = PH_ON;
                    n_elapsed = ELAPSED_W'(1);
                end else begin
                    n_elapsed = el_inc;
                    if (el_inc >= two_u) begin
                        n_pattern = '0;
                        n_count   = '0;
                        n_phase   = PH_GAP_CHR;
                    end
                end
            end
            PH_GAP_CHR: begin
                if (light_on) begin
                    n_phase   = PH_ON;
                    n_elapsed = ELAPSED_W'(1);
                end else begin
                    n_elapsed = el_inc;
                    if (el_inc >= four_u) begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // Event output
    always_comb begin
        ev_vld  = 1'b0;
        ev_kind = EV_DOT;
        ev_char = CH_NONE;
        case (r_phase)
            PH_ON: begin
                if (!light_on) begin
                    ev_vld = 1'b1;
                    if (r_elapsed < two_u) begin
                        ev_kind = EV_DOT;
                        ev_char = CH_DOT;
                    end else begin
                        ev_kind = EV_DASH;
                        ev_char = CH_DASH;
                    end
                end
            end
            PH_GAP_SYM: begin
                if (!light_on && el_inc >= two_u) begin
                    ev_vld  = 1'b1;
                    ev_kind = EV_CHAR;
                    ev_char = morse_lookup(PAT_MAX_W'(r_pattern), r_count);
                end
            end
            PH_GAP_CHR: begin
                if (!light_on && el_inc >= four_u) begin
                    ev_vld  = 1'b1;
                    ev_kind = EV_WORD;
                    ev_char = CH_NONE;
                end
            end
            default: ev_vld = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_unit      <= UNIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_THRESHOLD: r_threshold <= i_cfg_wdata[SAMPLE_W-1:0];
                CFG_UNIT:      r_unit      <= i_cfg_wdata[UNIT_W-1:0];
                default:       r_unit      <= r_unit;
            endcase
        end
    end

    // Input register: hold the sample until the decoder takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_accept) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_sample <= i_sample.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_elapsed <= '0;
            r_pattern <= '0;
            r_count   <= '0;
        end else if (advance) begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_pattern <= n_pattern;
            r_count   <= n_count;
        end
    end

    // Output register: load a new event, or drop the one taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= ev_vld;
        end else if (o_event.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && ev_vld) begin
            r_out_kind <= ev_kind;
            r_out_char <= ev_char;
        end
    end

    assign o_event.valid      = r_out_vld;
    assign o_event.event_kind = r_out_kind;
    assign o_event.char_code  = r_out_char;

endmodule
